// ===== src/sprite_blit_color_key_clip_core_defines.svh =====
// Assertion macros for the sprite blit core.
// No dependencies; included by files that carry concurrent checks.
`ifndef SPRITE_BLIT_COLOR_KEY_CLIP_CORE_DEFINES_SVH
`define SPRITE_BLIT_COLOR_KEY_CLIP_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define SBCK_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SBCK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SBCK_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SBCK_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/sbck_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the sprite blit core.
// No dependencies.
package sbck_pkg;

    localparam int COL_W      = 12;
    localparam int OFS_W      = 16;
    localparam int CHAR_W     = 8;
    localparam int SCR_W_W    = 8;
    localparam int SCR_H_W    = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int COORD_W    = 18;
    localparam int CELL_W     = 2 * CHAR_W;

    localparam logic [SCR_W_W-1:0] SCR_W_RESET = 8'd80;
    localparam logic [SCR_H_W-1:0] SCR_H_RESET = 7'd25;

    typedef enum logic [1:0] {
        MODE_DRAW  = 2'd0,
        MODE_READ  = 2'd1,
        MODE_CLEAR = 2'd2
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCREEN_WIDTH  = 3'd0,
        CFG_SCREEN_HEIGHT = 3'd1,
        CFG_TRANSPARENT   = 3'd2,
        CFG_CAMERA_X      = 3'd3,
        CFG_CAMERA_Y      = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADDR,
        ST_ACCESS,
        ST_RDATA,
        ST_CLEAR
    } t_state;

endpackage

// ===== src/sbck_ram.sv =====
`timescale 1ns / 1ps
// Single-port frame store with registered read.
// No dependencies.
module sbck_ram #(
    parameter int DEPTH = 8192,
    parameter int AW    = 13,
    parameter int DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic          i_re,
    input  logic [AW-1:0] i_addr,
    input  logic [DW-1:0] i_wdata,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/sbck_clip.sv =====
`timescale 1ns / 1ps
// Destination adder, screen clip test and store address generation.
// Depends on sbck_pkg.
module sbck_clip #(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 64,
    parameter int AW       = 13
) (
    input  logic                                i_clk,
    input  logic                                i_load,
    input  logic                                i_add_ofs,
    input  logic                                i_add_cam,
    input  logic        [sbck_pkg::COL_W-1:0]   i_col,
    input  logic        [sbck_pkg::COL_W-1:0]   i_row,
    input  logic signed [sbck_pkg::OFS_W-1:0]   i_ofs_x,
    input  logic signed [sbck_pkg::OFS_W-1:0]   i_ofs_y,
    input  logic signed [sbck_pkg::OFS_W-1:0]   i_cam_x,
    input  logic signed [sbck_pkg::OFS_W-1:0]   i_cam_y,
    input  logic        [sbck_pkg::SCR_W_W-1:0] i_scr_w,
    input  logic        [sbck_pkg::SCR_H_W-1:0] i_scr_h,
    output logic                                o_inside,
    output logic        [AW-1:0]                o_addr
);
    import sbck_pkg::*;

    localparam int XW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int YW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    localparam logic signed [COORD_W-1:0] C_MAX_COLS = COORD_W'(MAX_COLS);
    localparam logic signed [COORD_W-1:0] C_MAX_ROWS = COORD_W'(MAX_ROWS);

    logic signed [COORD_W-1:0] r_dx, r_dy, n_dx, n_dy;
    logic signed [COORD_W-1:0] w_col, w_row, w_ox, w_oy, w_cx, w_cy;
    logic signed [COORD_W-1:0] w_scr_w, w_scr_h;
    logic                      r_inside, n_inside;
    logic [AW-1:0]             r_addr, n_addr;

    always_comb begin
        w_col = $signed({{(COORD_W-COL_W){1'b0}}, i_col});
        w_row = $signed({{(COORD_W-COL_W){1'b0}}, i_row});
        w_ox  = i_add_ofs ? COORD_W'(i_ofs_x) : '0;
        w_oy  = i_add_ofs ? COORD_W'(i_ofs_y) : '0;
        w_cx  = i_add_cam ? COORD_W'(i_cam_x) : '0;
        w_cy  = i_add_cam ? COORD_W'(i_cam_y) : '0;
        n_dx  = w_col + w_ox + w_cx;
        n_dy  = w_row + w_oy + w_cy;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_dx <= n_dx;
            r_dy <= n_dy;
        end
    end

    always_comb begin
        w_scr_w  = $signed({{(COORD_W-SCR_W_W){1'b0}}, i_scr_w});
        w_scr_h  = $signed({{(COORD_W-SCR_H_W){1'b0}}, i_scr_h});
        n_inside = !r_dx[COORD_W-1] && !r_dy[COORD_W-1]
                && (r_dx < w_scr_w) && (r_dx < C_MAX_COLS)
                && (r_dy < w_scr_h) && (r_dy < C_MAX_ROWS);
        n_addr   = AW'(AW'(r_dy[YW-1:0]) * AW'(MAX_COLS)) + AW'(r_dx[XW-1:0]);
    end

    always_ff @(posedge i_clk) begin
        r_inside <= n_inside;
        r_addr   <= n_addr;
    end

    assign o_inside = r_inside;
    assign o_addr   = r_addr;

endmodule

// ===== src/sprite_blit_color_key_clip_core.sv =====
`timescale 1ns / 1ps
// Draw: states ADDR then ACCESS, then the registered result; next item accepted once idle.
// Read: result after the clip stage plus the registered store read; next item once idle.
// Unused mode: result the next cycle. Clear: zeros every store address, result after.
// After reset the store is zeroed with busy high, no result.
// Results are single-cycle strobes on o_done; the receiver cannot stall.
`include "sprite_blit_color_key_clip_core_defines.svh"
module sprite_blit_color_key_clip_core #(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [1:0]                             i_mode,
    input  logic        [sbck_pkg::COL_W-1:0]      i_cell_col,
    input  logic        [sbck_pkg::COL_W-1:0]      i_cell_row,
    input  logic signed [sbck_pkg::OFS_W-1:0]      i_offset_x,
    input  logic signed [sbck_pkg::OFS_W-1:0]      i_offset_y,
    input  logic        [sbck_pkg::CHAR_W-1:0]     i_cell_char,
    input  logic        [sbck_pkg::CHAR_W-1:0]     i_cell_color,
    input  logic                                   i_use_camera,
    input  logic                                   i_cfg_we,
    input  logic        [sbck_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic        [sbck_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                                   o_done,
    output logic                                   o_cell_written,
    output logic        [sbck_pkg::CHAR_W-1:0]     o_read_char,
    output logic        [sbck_pkg::CHAR_W-1:0]     o_read_color
);
    import sbck_pkg::*;

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    logic [SCR_W_W-1:0]       r_scr_w;
    logic [SCR_H_W-1:0]       r_scr_h;
    logic [CHAR_W-1:0]        r_key;
    logic signed [OFS_W-1:0]  r_cam_x, r_cam_y;

    t_state                   r_state, n_state;
    logic [AW-1:0]            r_clr_addr, n_clr_addr;
    logic                     r_clr_item, n_clr_item;
    logic                     r_done, n_done;
    logic                     r_written, n_written;
    logic [CHAR_W-1:0]        r_rch, n_rch, r_rco, n_rco;
    logic [CHAR_W-1:0]        r_char, r_color;
    logic                     r_is_read;

    logic                     w_load, w_add_ofs, w_add_cam;
    logic                     w_we, w_re;
    logic [AW-1:0]            w_addr;
    logic [CELL_W-1:0]        w_wdata, w_rdata;
    logic                     w_inside;
    logic [AW-1:0]            w_clip_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scr_w <= SCR_W_RESET;
            r_scr_h <= SCR_H_RESET;
            r_key   <= '0;
            r_cam_x <= '0;
            r_cam_y <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SCREEN_WIDTH:  r_scr_w <= i_cfg_data[SCR_W_W-1:0];
                CFG_SCREEN_HEIGHT: r_scr_h <= i_cfg_data[SCR_H_W-1:0];
                CFG_TRANSPARENT:   r_key   <= i_cfg_data[CHAR_W-1:0];
                CFG_CAMERA_X:      r_cam_x <= $signed(i_cfg_data[OFS_W-1:0]);
                CFG_CAMERA_Y:      r_cam_y <= $signed(i_cfg_data[OFS_W-1:0]);
                default: ;
            endcase
        end
    end

    assign w_add_ofs = (t_mode'(i_mode) == MODE_DRAW);
    assign w_add_cam = w_add_ofs && i_use_camera;

    sbck_clip #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS),
        .AW       (AW)
    ) u_clip (
        .i_clk     (i_clk),
        .i_load    (w_load),
        .i_add_ofs (w_add_ofs),
        .i_add_cam (w_add_cam),
        .i_col     (i_cell_col),
        .i_row     (i_cell_row),
        .i_ofs_x   (i_offset_x),
        .i_ofs_y   (i_offset_y),
        .i_cam_x   (r_cam_x),
        .i_cam_y   (r_cam_y),
        .i_scr_w   (r_scr_w),
        .i_scr_h   (r_scr_h),
        .o_inside  (w_inside),
        .o_addr    (w_clip_addr)
    );

    sbck_ram #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (CELL_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_re    (w_re),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_clr_item = r_clr_item;
        n_done     = 1'b0;
        n_written  = 1'b0;
        n_rch      = '0;
        n_rco      = '0;
        w_load     = 1'b0;
        w_we       = 1'b0;
        w_re       = 1'b0;
        w_addr     = w_clip_addr;
        w_wdata    = {r_color, r_char};
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    case (t_mode'(i_mode))
                        MODE_DRAW, MODE_READ: begin
                            w_load  = 1'b1;
                            n_state = ST_ADDR;
                        end
                        MODE_CLEAR: begin
                            n_clr_addr = '0;
                            n_clr_item = 1'b1;
                            n_state    = ST_CLEAR;
                        end
                        default: n_done = 1'b1;
                    endcase
                end
            end
            ST_ADDR: n_state = ST_ACCESS;
            ST_ACCESS: begin
                if (r_is_read) begin
                    w_re    = 1'b1;
                    n_state = ST_RDATA;
                end else begin
                    if (w_inside && (r_char != r_key)) begin
                        w_we      = 1'b1;
                        n_written = 1'b1;
                    end
                    n_done  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_RDATA: begin
                if (w_inside) begin
                    n_rch = w_rdata[CHAR_W-1:0];
                    n_rco = w_rdata[CELL_W-1:CHAR_W];
                end
                n_done  = 1'b1;
                n_state = ST_IDLE;
            end
            ST_CLEAR: begin
                w_we    = 1'b1;
                w_addr  = r_clr_addr;
                w_wdata = '0;
                if (r_clr_addr == LAST_ADDR) begin
                    n_done     = r_clr_item;
                    n_clr_item = 1'b0;
                    n_state    = ST_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_clr_item <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_clr_item <= n_clr_item;
            r_done     <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_written <= n_written;
        r_rch     <= n_rch;
        r_rco     <= n_rco;
        if (w_load) begin
            r_char    <= i_cell_char;
            r_color   <= i_cell_color;
            r_is_read <= (t_mode'(i_mode) == MODE_READ);
        end
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_done         = r_done;
    assign o_cell_written = r_written;
    assign o_read_char    = r_rch;
    assign o_read_color   = r_rco;

    `SBCK_ASSERT_NEXT(a_accept_progress, i_clk, i_rst_n, start && !busy, busy || o_done)
    `SBCK_ASSERT_IMPL(a_write_no_read, i_clk, i_rst_n, o_done && o_cell_written, (o_read_char == '0) && (o_read_color == '0))
    `SBCK_ASSERT_IMPL(a_we_state, i_clk, i_rst_n, w_we, (r_state == ST_ACCESS) || (r_state == ST_CLEAR))

endmodule
